>>> design/msp_frame_deframer_core_defines.svh
// Assertion macros for the MSP frame deframer.
`ifndef MSP_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define MSP_FRAME_DEFRAMER_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define MSPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define MSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MSPD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/mspd_pkg.sv
// Shared types, codes and the CRC-8 step for the MSP frame deframer.
`default_nettype none
package mspd_pkg;

  // Frame-end status codes
  localparam logic [2:0] ST_V1_OK     = 3'd0;
  localparam logic [2:0] ST_V2_OK     = 3'd1;
  localparam logic [2:0] ST_TUN_OK    = 3'd2;
  localparam logic [2:0] ST_V1_BAD    = 3'd3;
  localparam logic [2:0] ST_V2_BAD    = 3'd4;
  localparam logic [2:0] ST_TUN_BAD   = 3'd5;

  // Result kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Framing bytes
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_V1    = 8'h4D;  // 'M'
  localparam logic [7:0] CH_V2    = 8'h58;  // 'X'
  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'

  localparam logic [7:0]  TUNNEL_CMD   = 8'd255;
  localparam logic [7:0]  CRC_POLY     = 8'hD5;
  localparam logic [2:0]  TUNNEL_START = 3'd5;
  localparam logic [16:0] TUNNEL_HDR   = 17'd6;

  // One result item
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [2:0]  frame_status;
    logic [15:0] command;
    logic [7:0]  frame_flags;
    logic [2:0]  payload_start;
    logic [15:0] payload_count;
  } res_t;

  // CRC-8, poly 0xD5, MSB first, one byte
  function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] din);
    logic [7:0] v;
    v = crc ^ din;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage
`default_nettype wire

>>> design/msp_frame_deframer_core.sv
// MSP frame deframer top level: input register, parser, result handshake.
// Byte path: input register, then parser into the result register (out_valid).
// One byte per cycle when not stalled; the CRC-8 byte update is combinational.
// The input register only holds when the result register is full and stalled.
// Reset (rst_n low, synchronous): parser returns to idle, both valid bits clear.
`default_nettype none
`include "msp_frame_deframer_core_defines.svh"
module msp_frame_deframer_core
  import mspd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_kind,
  output logic [7:0]       out_payload_byte,
  output logic [15:0]      out_payload_index,
  output logic [2:0]       out_frame_status,
  output logic [15:0]      out_command,
  output logic [7:0]       out_frame_flags,
  output logic [2:0]       out_payload_start,
  output logic [15:0]      out_payload_count
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       res_free;
  logic       step;
  logic       res_vld;
  res_t       res;

  // Result register may load when empty or being taken
  assign res_free = !res_vld || !out_stall;
  assign step     = in_vld_r && res_free;
  assign in_stall = in_vld_r && !res_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  mspd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rx_byte  (in_byte_r),
    .res_free (res_free),
    .res_vld_r(res_vld),
    .res_r    (res)
  );

  assign out_valid         = res_vld;
  assign out_result_kind   = res.result_kind;
  assign out_payload_byte  = res.payload_byte;
  assign out_payload_index = res.payload_index;
  assign out_frame_status  = res.frame_status;
  assign out_command       = res.command;
  assign out_frame_flags   = res.frame_flags;
  assign out_payload_start = res.payload_start;
  assign out_payload_count = res.payload_count;

  // Checks
  `MSPD_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, out_valid && out_stall)
  `MSPD_ASSERT_NOW(a_status_range, clk, rst_n, out_valid && out_result_kind == KIND_END, out_frame_status <= ST_TUN_BAD)
  `MSPD_ASSERT_NOW(a_byte_item_clean, clk, rst_n, out_valid && out_result_kind == KIND_BYTE, out_frame_status == ST_V1_OK && out_command == 16'd0 && out_payload_count == 16'd0)
  `MSPD_ASSERT_NOW(a_tunnel_start, clk, rst_n, out_valid && out_payload_start != 3'd0, out_payload_start == TUNNEL_START && (out_frame_status == ST_TUN_OK || out_frame_status == ST_TUN_BAD))

endmodule
`default_nettype wire

>>> design/mspd_parser.sv
// Byte-wise MSP v1/v2 parser with registered result stage.
`default_nettype none
module mspd_parser
  import mspd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,      // a byte is consumed this cycle
  input  wire logic [7:0] rx_byte,
  input  wire logic       res_free,  // result register may load
  output logic            res_vld_r,
  output res_t            res_r
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_HDR, PH_DIR1, PH_SIZE, PH_CMD, PH_PAY1, PH_CHK1,
    PH_DIR2, PH_FLAGS, PH_IDL, PH_IDH, PH_LENL, PH_LENH, PH_PAY2, PH_CRC2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  crc_prev_r, crc_prev_nxt;
  logic [7:0]  last_r, last_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [15:0] tun_len_r, tun_len_nxt;
  logic [15:0] tun_id_r, tun_id_nxt;

  logic        has_res;
  res_t        res_nxt;
  logic [7:0]  crc_step;
  logic [15:0] cnt_inc;
  logic        tunnel_hit;

  assign crc_step = crc8_d5(crc_r, rx_byte);
  assign cnt_inc  = cnt_r + 16'd1;
  assign tunnel_hit = (cmd_r == {8'd0, TUNNEL_CMD}) && (cnt_r >= 16'd6) &&
                      ({1'b0, cnt_r} == ({1'b0, tun_len_r} + TUNNEL_HDR));

  // Next-state and result decode for one byte.
  // Fields not cleared on return to idle are always reloaded before use.
  always_comb begin
    phase_nxt     = phase_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    xor_nxt       = xor_r;
    crc_nxt       = crc_r;
    crc_prev_nxt  = crc_prev_r;
    last_nxt      = last_r;
    cmd_nxt       = cmd_r;
    flags_nxt     = flags_r;
    tun_len_nxt   = tun_len_r;
    tun_id_nxt    = tun_id_r;
    has_res       = 1'b0;
    res_nxt       = '0;

    unique case (phase_r)
      PH_IDLE: begin
        phase_nxt = (rx_byte == CH_START) ? PH_HDR : PH_IDLE;
      end
      PH_HDR: begin
        if (rx_byte == CH_V1) begin
          phase_nxt = PH_DIR1;
        end else if (rx_byte == CH_V2) begin
          phase_nxt = PH_DIR2;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_DIR1: begin
        phase_nxt = (rx_byte == CH_LT || rx_byte == CH_GT) ? PH_SIZE : PH_IDLE;
      end
      PH_SIZE: begin
        len_nxt   = {8'd0, rx_byte};
        xor_nxt   = rx_byte;
        cnt_nxt   = '0;
        crc_nxt   = '0;
        phase_nxt = PH_CMD;
      end
      PH_CMD: begin
        cmd_nxt   = {8'd0, rx_byte};
        xor_nxt   = xor_r ^ rx_byte;
        phase_nxt = (len_r == 16'd0) ? PH_CHK1 : PH_PAY1;
      end
      PH_PAY1: begin
        has_res               = 1'b1;
        res_nxt.result_kind   = KIND_BYTE;
        res_nxt.payload_byte  = rx_byte;
        res_nxt.payload_index = cnt_r;
        xor_nxt      = xor_r ^ rx_byte;
        crc_prev_nxt = crc_r;
        crc_nxt      = crc_step;
        last_nxt     = rx_byte;
        // Tunnel header capture from the first five payload bytes
        case (cnt_r)
          16'd0:   flags_nxt = rx_byte;
          16'd1:   tun_id_nxt[7:0] = rx_byte;
          16'd2:   tun_id_nxt[15:8] = rx_byte;
          16'd3:   tun_len_nxt[7:0] = rx_byte;
          16'd4:   tun_len_nxt[15:8] = rx_byte;
          default: ;
        endcase
        cnt_nxt = cnt_inc;
        if (cnt_inc >= len_r) begin
          phase_nxt = PH_CHK1;
        end
      end
      PH_CHK1: begin
        has_res             = 1'b1;
        res_nxt.result_kind = KIND_END;
        if (xor_r != rx_byte) begin
          res_nxt.frame_status  = ST_V1_BAD;
          res_nxt.command       = cmd_r;
          res_nxt.payload_count = len_r;
        end else if (tunnel_hit) begin
          res_nxt.frame_status  = (crc_prev_r == last_r) ? ST_TUN_OK : ST_TUN_BAD;
          res_nxt.command       = tun_id_r;
          res_nxt.frame_flags   = flags_r;
          res_nxt.payload_start = TUNNEL_START;
          res_nxt.payload_count = tun_len_r;
        end else begin
          res_nxt.frame_status  = ST_V1_OK;
          res_nxt.command       = cmd_r;
          res_nxt.payload_count = len_r;
        end
        phase_nxt = PH_IDLE;
      end
      PH_DIR2: begin
        if (rx_byte == CH_LT || rx_byte == CH_GT) begin
          phase_nxt = PH_FLAGS;
          crc_nxt   = '0;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_FLAGS: begin
        flags_nxt = rx_byte;
        crc_nxt   = crc_step;
        phase_nxt = PH_IDL;
      end
      PH_IDL: begin
        cmd_nxt   = {8'd0, rx_byte};
        crc_nxt   = crc_step;
        phase_nxt = PH_IDH;
      end
      PH_IDH: begin
        cmd_nxt   = {rx_byte, cmd_r[7:0]};
        crc_nxt   = crc_step;
        phase_nxt = PH_LENL;
      end
      PH_LENL: begin
        len_nxt   = {8'd0, rx_byte};
        crc_nxt   = crc_step;
        phase_nxt = PH_LENH;
      end
      PH_LENH: begin
        len_nxt   = {rx_byte, len_r[7:0]};
        crc_nxt   = crc_step;
        cnt_nxt   = '0;
        phase_nxt = ({rx_byte, len_r[7:0]} == 16'd0) ? PH_CRC2 : PH_PAY2;
      end
      PH_PAY2: begin
        has_res               = 1'b1;
        res_nxt.result_kind   = KIND_BYTE;
        res_nxt.payload_byte  = rx_byte;
        res_nxt.payload_index = cnt_r;
        crc_nxt = crc_step;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= len_r) begin
          phase_nxt = PH_CRC2;
        end
      end
      PH_CRC2: begin
        has_res               = 1'b1;
        res_nxt.result_kind   = KIND_END;
        res_nxt.frame_status  = (crc_r == rx_byte) ? ST_V2_OK : ST_V2_BAD;
        res_nxt.command       = cmd_r;
        res_nxt.frame_flags   = flags_r;
        res_nxt.payload_count = len_r;
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Parser state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      len_r       <= '0;
      cnt_r       <= '0;
      xor_r       <= '0;
      crc_r       <= '0;
      crc_prev_r  <= '0;
      last_r      <= '0;
      cmd_r       <= '0;
      flags_r     <= '0;
      tun_len_r   <= '0;
      tun_id_r    <= '0;
      res_vld_r   <= 1'b0;
    end else begin
      if (step) begin
        phase_r     <= phase_nxt;
        len_r       <= len_nxt;
        cnt_r       <= cnt_nxt;
        xor_r       <= xor_nxt;
        crc_r       <= crc_nxt;
        crc_prev_r  <= crc_prev_nxt;
        last_r      <= last_nxt;
        cmd_r       <= cmd_nxt;
        flags_r     <= flags_nxt;
        tun_len_r   <= tun_len_nxt;
        tun_id_r    <= tun_id_nxt;
      end
      if (res_free) begin
        res_vld_r <= step && has_res;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (res_free && step && has_res) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire
